FILE: hw/rtl/kvt_pkg.sv
package kvt_pkg;

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_SET     = 2'd1,
    FN_DEL     = 2'd2,
    FN_INVALID = 2'd3
  } kvt_func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INVALID   = 2'd2,
    ST_FULL      = 2'd3
  } kvt_status_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
  } kvt_entry_t;

  typedef struct packed {
    logic re;
    logic we;
  } kvt_mem_ctl_t;

endpackage

FILE: hw/rtl/kvt_intf.sv
interface kvt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink (input valid, input func, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink (input valid, input status, input read_value, output ready);
endinterface

FILE: hw/rtl/kvt_mem.sv
module kvt_mem #(
  parameter int SLOTS = 64,
  parameter int AW    = 6
) (
  input  logic                  clk_i,
  input  kvt_pkg::kvt_mem_ctl_t ctl_i,
  input  logic [AW-1:0]         addr_i,
  input  kvt_pkg::kvt_entry_t   wdata_i,
  output kvt_pkg::kvt_entry_t   rdata_o
);
  import kvt_pkg::*;

  kvt_entry_t mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

FILE: hw/rtl/kvt_ctrl.sv
module kvt_ctrl #(
  parameter int SLOTS = 64,
  parameter int AW    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kvt_req_if.sink               req_i,
  kvt_rsp_if.source             rsp_o,
  output kvt_pkg::kvt_mem_ctl_t mem_ctl_o,
  output logic [AW-1:0]         mem_addr_o,
  output kvt_pkg::kvt_entry_t   mem_wdata_o,
  input  kvt_pkg::kvt_entry_t   mem_rdata_i
);
  import kvt_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam logic [AW-1:0] LastIdx = AW'(SLOTS - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          issuing_q, issuing_d;
  logic          rvalid_q, rvalid_d;
  logic [AW-1:0] ridx_q;
  logic          found_q, found_d;
  logic          free_found_q, free_found_d;
  logic          out_valid_q, out_valid_d;

  kvt_func_e     func_q;
  logic [31:0]   key_q, value_q;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic [31:0]   match_val_q, match_val_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  kvt_status_e   res_status_q, res_status_d;
  logic [31:0]   res_val_q, res_val_d;
  kvt_status_e   out_status_q;
  logic [31:0]   out_val_q;

  logic accept, out_free, scan_end, load_out;

  assign req_i.ready      = (state_q == S_IDLE);
  assign accept           = req_i.valid && req_i.ready;
  assign out_free         = !out_valid_q || rsp_o.ready;
  assign scan_end         = (state_q == S_SCAN) && !issuing_q && !rvalid_q;
  assign load_out         = (state_q == S_DONE) && out_free;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_value = out_val_q;

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    issuing_d    = issuing_q;
    rvalid_d     = 1'b0;
    found_d      = found_q;
    free_found_d = free_found_q;
    match_idx_d  = match_idx_q;
    match_val_d  = match_val_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    mem_ctl_o    = '0;
    mem_addr_o   = addr_q;
    mem_wdata_o  = '{valid: 1'b1, key: key_q, value: value_q};

    // a returned entry from the scan
    if (rvalid_q) begin
      if (mem_rdata_i.valid && mem_rdata_i.key == key_q && !found_q) begin
        found_d     = 1'b1;
        match_idx_d = ridx_q;
        match_val_d = mem_rdata_i.value;
      end
      if (!mem_rdata_i.valid && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = ridx_q;
      end
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_ctl_o.we      = 1'b1;
        mem_wdata_o.valid = 1'b0;
        addr_d            = addr_q + 1'b1;
        if (addr_q == LastIdx) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          found_d      = 1'b0;
          free_found_d = 1'b0;
          addr_d       = '0;
          if (kvt_func_e'(req_i.func) == FN_INVALID) begin
            res_status_d = ST_INVALID;
            res_val_d    = '0;
            state_d      = S_DONE;
          end else begin
            issuing_d = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issuing_q) begin
          mem_ctl_o.re = 1'b1;
          rvalid_d     = 1'b1;
          addr_d       = addr_q + 1'b1;
          if (addr_q == LastIdx) begin
            issuing_d = 1'b0;
          end
        end
        if (scan_end) begin
          res_status_d = ST_OK;
          res_val_d    = '0;
          unique case (func_q)
            FN_GET: begin
              if (found_q) begin
                res_val_d = match_val_q;
              end else begin
                res_status_d = ST_NOT_FOUND;
              end
            end
            FN_SET: begin
              if (found_q) begin
                mem_ctl_o.we = 1'b1;
                mem_addr_o   = match_idx_q;
              end else if (free_found_q) begin
                mem_ctl_o.we = 1'b1;
                mem_addr_o   = free_idx_q;
              end else begin
                res_status_d = ST_FULL;
              end
            end
            FN_DEL: begin
              mem_wdata_o.valid = 1'b0;
              mem_ctl_o.we      = found_q;
              mem_addr_o        = match_idx_q;
            end
            FN_INVALID: begin
              res_status_d = ST_INVALID;
            end
            default: begin
              res_status_d = ST_INVALID;
            end
          endcase
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      issuing_q    <= 1'b0;
      rvalid_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      issuing_q    <= issuing_d;
      rvalid_q     <= rvalid_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= addr_q;
    match_idx_q  <= match_idx_d;
    match_val_q  <= match_val_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    if (accept) begin
      func_q  <= kvt_func_e'(req_i.func);
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_val_q    <= res_val_q;
    end
  end

endmodule

FILE: hw/rtl/key_value_table.sv
// channel  dir  handshake      payload
// req_i    in   valid/ready    func[1:0], key[31:0] signed, value[31:0] signed
// rsp_o    out  valid/ready    status[1:0], read_value[31:0] signed
//
// one item at a time: get, set and delete each scan the entry memory through its
// single read port, one slot a cycle; an invalid command skips the scan and goes
// straight to its result
// after reset a clearing pass writes every slot invalid,
// no request is taken meanwhile
// a result waits in the output register while the next item is accepted
module key_value_table #(
  parameter int SLOTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kvt_req_if.sink   req_i,
  kvt_rsp_if.source rsp_o
);
  import kvt_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  kvt_mem_ctl_t  mem_ctl;
  logic [AW-1:0] mem_addr;
  kvt_entry_t    mem_wdata;
  kvt_entry_t    mem_rdata;

  kvt_ctrl #(
    .SLOTS(SLOTS),
    .AW   (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .mem_ctl_o  (mem_ctl),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  kvt_mem #(
    .SLOTS(SLOTS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

`ifndef SYNTHESIS
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.re && mem_ctl.we))
    else $error("entry memory read and written in one cycle");

  a_idle_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!mem_ctl.re && !mem_ctl.we))
    else $error("memory access while taking requests");

  a_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.read_value != 32'sd0) |-> (rsp_o.status == ST_OK))
    else $error("nonzero read value with failing status");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second item taken before the first finished");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kvt_pkg::*;

  localparam int SLOTS = 64;
  localparam int POOL_SIZE = 96;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct {
    kvt_func_e   func;
    logic [31:0] key;
    logic [31:0] value;
  } table_req_t;

  typedef struct {
    kvt_status_e status;
    logic [31:0] read_value;
  } table_rsp_t;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } mix_e;

  logic clk_i;
  logic rst_ni;

  kvt_req_if req();
  kvt_rsp_if rsp();

  key_value_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // predicted table contents
  logic        slot_used[SLOTS];
  logic [31:0] slot_key_q[SLOTS];
  logic [31:0] slot_value_q[SLOTS];

  table_req_t pending_req[$];
  table_rsp_t expected_rsp[$];
  logic [31:0] key_pool[POOL_SIZE];

  logic req_fire = 1'b0;
  int   send_gap = 0;
  logic send_quiet = 1'b0;
  int   stall_left = 0;
  logic recv_quiet = 1'b0;
  int   error_count = 0;
  int   accepted_count = 0;
  int   status_count[4] = '{0, 0, 0, 0};

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic table_rsp_t apply_table_op(table_req_t rq);
    table_rsp_t r;
    int hit;
    int free_slot;
    r.status = ST_OK;
    r.read_value = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_key_q[i] == rq.key) hit = i;
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    case (rq.func)
      FN_GET: begin
        if (hit >= 0) r.read_value = slot_value_q[hit];
        else r.status = ST_NOT_FOUND;
      end
      FN_SET: begin
        if (hit < 0) hit = free_slot;
        if (hit >= 0) begin
          slot_used[hit] = 1'b1;
          slot_key_q[hit] = rq.key;
          slot_value_q[hit] = rq.value;
        end else begin
          r.status = ST_FULL;
        end
      end
      FN_DEL: begin
        if (hit >= 0) slot_used[hit] = 1'b0;
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 80);
    return $urandom_range(100, 250);
  endfunction

  function automatic kvt_func_e random_func(mix_e mix);
    int r;
    int set_w;
    int get_w;
    int del_w;
    r = $urandom_range(0, 99);
    case (mix)
      PH_FILL: begin
        set_w = 65; get_w = 20; del_w = 10;
      end
      PH_DRAIN: begin
        set_w = 15; get_w = 30; del_w = 50;
      end
      default: begin
        set_w = 35; get_w = 40; del_w = 20;
      end
    endcase
    if (r < set_w) return FN_SET;
    if (r < set_w + get_w) return FN_GET;
    if (r < set_w + get_w + del_w) return FN_DEL;
    return FN_INVALID;
  endfunction

  function automatic logic [31:0] random_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] random_value();
    // the first pool entries are the extremes
    if ($urandom_range(0, 9) == 0) return key_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  task automatic push_req(kvt_func_e f, logic [31:0] k, logic [31:0] v);
    table_req_t rq;
    rq.func = f;
    rq.key = k;
    rq.value = v;
    pending_req.push_back(rq);
  endtask

  // request driver
  always @(negedge clk_i) begin : req_driver
    table_req_t nxt;
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_fire) begin
      // hold the item until it is taken
    end else if (send_gap > 0) begin
      req.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_req.size() != 0) begin
      nxt = pending_req.pop_front();
      req.valid <= 1'b1;
      req.func  <= nxt.func;
      req.key   <= nxt.key;
      req.value <= nxt.value;
      send_gap  <= send_quiet ? 0 : idle_length();
      if ($urandom_range(0, 79) == 0) send_quiet <= !send_quiet;
    end else begin
      req.valid <= 1'b0;
    end
  end

  // response back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (!recv_quiet && $urandom_range(0, 3) == 0) stall_left <= idle_length();
      if ($urandom_range(0, 4999) == 0) recv_quiet <= !recv_quiet;
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk_i) begin : monitor
    table_req_t rq;
    table_rsp_t want;
    if (rst_ni) begin
      req_fire <= req.valid && req.ready;
      if (rsp.valid && rsp.ready) begin
        status_count[int'(rsp.status)]++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response, status %0d read_value %h", $time,
                   rsp.status, rsp.read_value);
          error_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     want.status, rsp.status);
            error_count++;
          end
          if (rsp.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h actual %h", $time,
                     want.read_value, rsp.read_value);
            error_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        rq.func  = kvt_func_e'(req.func);
        rq.key   = req.key;
        rq.value = req.value;
        expected_rsp.push_back(apply_table_op(rq));
        accepted_count++;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d responses outstanding", expected_rsp.size());
    $display("FAIL key_value_table");
    $finish;
  end

  initial begin : stimulus
    int random_left;
    int run;
    mix_e mix;
    req.valid = 1'b0;
    req.func  = FN_GET;
    req.key   = '0;
    req.value = '0;
    rsp.ready = 1'b0;
    rst_ni    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key_q[i] = '0;
      slot_value_q[i] = '0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    key_pool[4] = 32'h5555_5555;
    key_pool[5] = 32'haaaa_aaaa;
    key_pool[6] = 32'h0000_0001;
    for (int i = 7; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed: empty table, extremes, overwrite, delete of absent keys
    push_req(FN_GET, 32'h0000_0000, 32'h1234_5678);
    push_req(FN_DEL, 32'h0000_0005, 32'h0000_0000);
    push_req(FN_INVALID, 32'h7fff_ffff, 32'h7fff_ffff);
    push_req(FN_SET, 32'h8000_0000, 32'h7fff_ffff);
    push_req(FN_SET, 32'h7fff_ffff, 32'h8000_0000);
    push_req(FN_SET, 32'hffff_ffff, 32'hffff_ffff);
    push_req(FN_SET, 32'h0000_0000, 32'h0000_0000);
    push_req(FN_GET, 32'h8000_0000, 32'h0000_0000);
    push_req(FN_GET, 32'h7fff_ffff, 32'hffff_ffff);
    push_req(FN_GET, 32'hffff_ffff, 32'h0000_0000);
    push_req(FN_GET, 32'h0000_0000, 32'hffff_ffff);
    push_req(FN_SET, 32'hffff_ffff, 32'h0000_007b);
    push_req(FN_GET, 32'hffff_ffff, 32'h0000_0000);
    push_req(FN_DEL, 32'h7fff_ffff, 32'h0000_0000);
    push_req(FN_GET, 32'h7fff_ffff, 32'h0000_0000);
    push_req(FN_DEL, 32'h7fff_ffff, 32'h0000_0000);
    push_req(FN_SET, 32'h5555_5555, 32'haaaa_aaaa);
    push_req(FN_GET, 32'h5555_5555, 32'h0000_0000);
    push_req(FN_INVALID, 32'hffff_ffff, 32'h0000_0000);
    push_req(FN_GET, 32'hffff_ffff, 32'h0000_0000);
    push_req(FN_INVALID, 32'h0000_0000, 32'h8000_0000);

    // random: phases that fill the table to overflow, drain it, or mix
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      case ($urandom_range(0, 2))
        0: mix = PH_FILL;
        1: mix = PH_DRAIN;
        default: mix = PH_MIXED;
      endcase
      run = $urandom_range(100, 300);
      for (int n = 0; n < run && random_left > 0; n++) begin
        push_req(random_func(mix), random_key(), random_value());
        random_left--;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_req.size() != 0 || req.valid) @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_rsp.size());
      error_count++;
    end

    $display("%0d requests accepted over fill, drain and mixed phases with random stalls",
             accepted_count);
    $display("responses: %0d ok, %0d not found, %0d invalid, %0d table full",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (error_count == 0) begin
      $display("PASS key_value_table");
    end else begin
      $display("FAIL key_value_table");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_intf.sv
hw/rtl/kvt_mem.sv
hw/rtl/kvt_ctrl.sv
hw/rtl/key_value_table.sv
bench/testbench.sv
